// File: hdl/fbps_pkg.sv
// shared types and constants for the frame buffer pool selector
package fbps_pkg;

    typedef enum logic [2:0] {
        REQ_ASSIGN   = 3'd0,
        REQ_POST     = 3'd1,
        REQ_RELEASE  = 3'd2,
        REQ_RECONFIG = 3'd3,
        REQ_FLUSH    = 3'd4
    } t_req;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NO_BUFFER = 2'd1;
    localparam logic [1:0] ST_IGNORED   = 2'd2;

    localparam logic CFG_TRIM_LIMIT = 1'b0;
    localparam logic CFG_POOL_LIMIT = 1'b1;

    localparam logic [7:0] TRIM_LIMIT_RST = 8'd100;
    localparam logic [2:0] POOL_LIMIT_RST = 3'd4;
    localparam logic [7:0] RUN_MAX        = 8'hFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_FINISH,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic check;
        logic finish;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic in_assign;
        logic scan_last;
        logic trim;
    } t_stat;

endpackage

// File: hdl/fbps_ctrl.sv
// sequencer for the frame buffer pool selector
module fbps_ctrl import fbps_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_xfer;
    logic   out_free;

    assign in_xfer  = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = i_stat.in_assign ? S_SCAN : S_EXEC;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = S_CHECK;
                end
            end
            // a trim drops the chosen slot and rescans
            S_CHECK: n_state = i_stat.trim ? S_SCAN : S_FINISH;
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE:   o_cmd.load   = in_xfer;
            S_SCAN:   o_cmd.scan   = 1'b1;
            S_CHECK:  o_cmd.check  = 1'b1;
            S_FINISH: o_cmd.finish = out_free;
            S_EXEC:   o_cmd.exec   = out_free;
            default:  o_cmd        = '0;
        endcase
    end

    always_comb begin
        if (o_cmd.finish || o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (i_out_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: hdl/fbps_dp.sv
// slot state, scan accumulators and result register of the pool selector
module fbps_dp import fbps_pkg::*; #(
    parameter int SLOTS    = 4,
    parameter int AGE_BITS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_stat      o_stat,
    input  logic [2:0] i_req_type,
    input  logic [1:0] i_release_slot,
    input  logic       i_size_nonzero,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output logic [1:0] o_status,
    output logic [1:0] o_chosen_slot,
    output logic [7:0] o_buffer_age,
    output logic       o_allocated,
    output logic       o_trimmed,
    output logic [1:0] o_trimmed_slot
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int LW = (CW > 3) ? CW : 3;
    localparam logic [AGE_BITS-1:0] AGE_MAX  = {AGE_BITS{1'b1}};
    localparam logic [SW-1:0]       IDX_LAST = SW'(SLOTS - 1);
    localparam logic [SW+1:0]       SLOTS_R  = (SW + 2)'(SLOTS);
    localparam logic [LW-1:0]       SLOTS_L  = LW'(SLOTS);

    // configuration
    logic [7:0] r_trim_limit, n_trim_limit;
    logic [2:0] r_pool_limit, n_pool_limit;

    // captured request
    logic [2:0] r_req;
    logic [1:0] r_rel;
    logic       r_szn;

    // slot state
    logic [SLOTS-1:0]    r_valid, n_valid;
    logic [SLOTS-1:0]    r_busy, n_busy;
    logic [AGE_BITS-1:0] r_age [SLOTS];
    logic [AGE_BITS-1:0] n_age [SLOTS];
    logic [SW-1:0]       r_order [SLOTS];
    logic [SW-1:0]       n_order [SLOTS];
    logic [SW-1:0]       r_cur, n_cur;
    logic                r_cur_valid, n_cur_valid;
    logic [7:0]          r_idle_run, n_idle_run;

    // scan accumulators
    logic [SW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [CW-1:0]       r_nbusy, n_nbusy;
    logic                r_best_found, n_best_found;
    logic [SW-1:0]       r_best, n_best;
    logic [AGE_BITS-1:0] r_best_age, n_best_age;
    logic [SW-1:0]       r_best_order, n_best_order;
    logic                r_hole_found, n_hole_found;
    logic [SW-1:0]       r_hole, n_hole;
    logic                r_trimmed, n_trimmed;
    logic [SW-1:0]       r_tslot, n_tslot;

    // result register
    logic [1:0] r_o_status;
    logic [1:0] r_o_chosen;
    logic [7:0] r_o_age;
    logic       r_o_alloc;
    logic       r_o_trimmed;
    logic [1:0] r_o_tslot;

    // scan step helpers
    logic                scan_first;
    logic [CW-1:0]       cnt_b, nbusy_b;
    logic                bf_b, hf_b;
    logic [AGE_BITS-1:0] ba_b;
    logic [SW-1:0]       bo_b;
    logic                take;

    // check helpers
    logic          run_inc;
    logic [7:0]    run_next;
    logic          trim;

    // finish helpers
    logic [LW-1:0] lim, pool_l, cnt_l;
    logic          do_alloc;
    logic          success;
    logic [SW-1:0] sel;

    // exec helpers
    logic [SW+1:0] rel_w;
    logic [SW-1:0] rel_idx;
    logic          rel_ok;

    // result values
    logic [1:0]            res_status;
    logic [SW-1:0]         res_chosen;
    logic [AGE_BITS-1:0]   res_age;
    logic                  res_alloc;
    logic [SW+1:0]         chosen_w, tslot_w;
    logic [AGE_BITS+7:0]   age_w;

    assign scan_first = (r_idx == '0);
    assign cnt_b   = scan_first ? '0 : r_cnt;
    assign nbusy_b = scan_first ? '0 : r_nbusy;
    assign bf_b    = scan_first ? 1'b0 : r_best_found;
    assign hf_b    = scan_first ? 1'b0 : r_hole_found;
    assign ba_b    = r_best_age;
    assign bo_b    = r_best_order;
    assign take    = !bf_b || (r_age[r_idx] > ba_b) ||
                     ((r_age[r_idx] == ba_b) && (r_order[r_idx] < bo_b));

    assign run_inc  = (({1'b0, r_nbusy} + (CW + 1)'(1)) < {1'b0, r_cnt});
    assign run_next = run_inc ? ((r_idle_run == RUN_MAX) ? RUN_MAX : r_idle_run + 8'd1)
                              : 8'd0;
    assign trim     = r_best_found && (run_next > r_trim_limit);

    assign pool_l   = LW'(r_pool_limit);
    assign cnt_l    = LW'(r_cnt);
    assign lim      = (pool_l > SLOTS_L) ? SLOTS_L : pool_l;
    assign do_alloc = !r_best_found && (cnt_l < lim) && r_hole_found;
    assign success  = r_best_found || do_alloc;
    assign sel      = r_best_found ? r_best : r_hole;

    assign rel_w   = {SW'(0), r_rel};
    assign rel_idx = rel_w[SW-1:0];
    assign rel_ok  = (rel_w < SLOTS_R) ? r_valid[rel_idx] : 1'b0;

    assign o_stat.in_assign = (i_req_type == REQ_ASSIGN);
    assign o_stat.scan_last = (r_idx == IDX_LAST);
    assign o_stat.trim      = trim;

    always_comb begin
        n_trim_limit = r_trim_limit;
        n_pool_limit = r_pool_limit;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TRIM_LIMIT: n_trim_limit = i_cfg_data;
                CFG_POOL_LIMIT: n_pool_limit = i_cfg_data[2:0];
                default:        n_trim_limit = r_trim_limit;
            endcase
        end
    end

    always_comb begin
        n_valid      = r_valid;
        n_busy       = r_busy;
        n_age        = r_age;
        n_order      = r_order;
        n_cur        = r_cur;
        n_cur_valid  = r_cur_valid;
        n_idle_run   = r_idle_run;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_nbusy      = r_nbusy;
        n_best_found = r_best_found;
        n_best       = r_best;
        n_best_age   = r_best_age;
        n_best_order = r_best_order;
        n_hole_found = r_hole_found;
        n_hole       = r_hole;
        n_trimmed    = r_trimmed;
        n_tslot      = r_tslot;
        res_status   = ST_IGNORED;
        res_chosen   = '0;
        res_age      = '0;
        res_alloc    = 1'b0;

        if (i_cmd.load) begin
            n_trimmed = 1'b0;
            n_tslot   = '0;
        end

        // one slot per cycle, best free slot by age then by allocation rank
        if (i_cmd.scan) begin
            n_cnt        = cnt_b;
            n_nbusy      = nbusy_b;
            n_best_found = bf_b;
            n_hole_found = hf_b;
            if (r_valid[r_idx]) begin
                n_cnt = cnt_b + CW'(1);
                if (r_busy[r_idx]) begin
                    n_nbusy = nbusy_b + CW'(1);
                end else if (take) begin
                    n_best_found = 1'b1;
                    n_best       = r_idx;
                    n_best_age   = r_age[r_idx];
                    n_best_order = r_order[r_idx];
                end
            end else if (!hf_b) begin
                n_hole_found = 1'b1;
                n_hole       = r_idx;
            end
            n_idx = (r_idx == IDX_LAST) ? '0 : r_idx + SW'(1);
        end

        if (i_cmd.check) begin
            n_idle_run = trim ? 8'd0 : run_next;
            if (trim) begin
                if (!r_trimmed) begin
                    n_trimmed = 1'b1;
                    n_tslot   = r_best;
                end
                for (int k = 0; k < SLOTS; k++) begin
                    if (r_valid[k] && (r_order[k] > r_best_order)) begin
                        n_order[k] = r_order[k] - SW'(1);
                    end
                end
                n_valid[r_best] = 1'b0;
                n_busy[r_best]  = 1'b0;
                n_age[r_best]   = '0;
                n_order[r_best] = '0;
                if (r_cur_valid && (r_cur == r_best)) begin
                    n_cur_valid = 1'b0;
                end
            end
        end

        if (i_cmd.finish) begin
            if (success) begin
                // the fresh slot is still invalid here, so it keeps age zero
                for (int k = 0; k < SLOTS; k++) begin
                    if (r_valid[k] && (r_age[k] != AGE_MAX)) begin
                        n_age[k] = r_age[k] + AGE_BITS'(1);
                    end
                end
                if (do_alloc) begin
                    n_valid[r_hole] = 1'b1;
                    n_busy[r_hole]  = 1'b0;
                    n_age[r_hole]   = '0;
                    n_order[r_hole] = r_cnt[SW-1:0];
                    res_age         = '0;
                end else begin
                    res_age = (r_best_age == AGE_MAX) ? AGE_MAX
                                                      : r_best_age + AGE_BITS'(1);
                end
                n_cur       = sel;
                n_cur_valid = 1'b1;
                res_status  = ST_DONE;
                res_chosen  = sel;
                res_alloc   = do_alloc;
            end else begin
                for (int k = 0; k < SLOTS; k++) begin
                    n_age[k] = '0;
                end
                n_cur_valid = 1'b0;
                res_status  = ST_NO_BUFFER;
            end
        end

        if (i_cmd.exec) begin
            unique case (r_req)
                REQ_POST: begin
                    if (r_cur_valid) begin
                        n_busy[r_cur] = 1'b1;
                        n_age[r_cur]  = '0;
                        n_cur_valid   = 1'b0;
                        res_status    = ST_DONE;
                    end
                end
                REQ_RELEASE: begin
                    if (rel_ok) begin
                        n_busy[rel_idx] = 1'b0;
                        res_status      = ST_DONE;
                    end
                end
                REQ_RECONFIG, REQ_FLUSH: begin
                    if (r_szn || (r_req == REQ_FLUSH)) begin
                        n_valid     = '0;
                        n_busy      = '0;
                        n_cur_valid = 1'b0;
                        for (int k = 0; k < SLOTS; k++) begin
                            n_age[k]   = '0;
                            n_order[k] = '0;
                        end
                        res_status = ST_DONE;
                    end
                end
                default: res_status = ST_IGNORED;
            endcase
        end
    end

    assign chosen_w = {2'b00, res_chosen};
    assign tslot_w  = {2'b00, r_tslot};
    assign age_w    = {8'h00, res_age};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trim_limit <= TRIM_LIMIT_RST;
            r_pool_limit <= POOL_LIMIT_RST;
            r_valid      <= '0;
            r_busy       <= '0;
            for (int k = 0; k < SLOTS; k++) begin
                r_age[k]   <= '0;
                r_order[k] <= '0;
            end
            r_cur        <= '0;
            r_cur_valid  <= 1'b0;
            r_idle_run   <= 8'd0;
            r_idx        <= '0;
            r_cnt        <= '0;
            r_nbusy      <= '0;
            r_best_found <= 1'b0;
            r_hole_found <= 1'b0;
            r_trimmed    <= 1'b0;
        end else begin
            r_trim_limit <= n_trim_limit;
            r_pool_limit <= n_pool_limit;
            r_valid      <= n_valid;
            r_busy       <= n_busy;
            r_age        <= n_age;
            r_order      <= n_order;
            r_cur        <= n_cur;
            r_cur_valid  <= n_cur_valid;
            r_idle_run   <= n_idle_run;
            r_idx        <= n_idx;
            r_cnt        <= n_cnt;
            r_nbusy      <= n_nbusy;
            r_best_found <= n_best_found;
            r_hole_found <= n_hole_found;
            r_trimmed    <= n_trimmed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best       <= n_best;
        r_best_age   <= n_best_age;
        r_best_order <= n_best_order;
        r_hole       <= n_hole;
        r_tslot      <= n_tslot;
        if (i_cmd.load) begin
            r_req <= i_req_type;
            r_rel <= i_release_slot;
            r_szn <= i_size_nonzero;
        end
        if (i_cmd.finish || i_cmd.exec) begin
            r_o_status  <= res_status;
            r_o_chosen  <= chosen_w[1:0];
            r_o_age     <= age_w[7:0];
            r_o_alloc   <= res_alloc;
            r_o_trimmed <= i_cmd.finish ? r_trimmed : 1'b0;
            r_o_tslot   <= i_cmd.finish ? tslot_w[1:0] : 2'b00;
        end
    end

    assign o_status       = r_o_status;
    assign o_chosen_slot  = r_o_chosen;
    assign o_buffer_age   = r_o_age;
    assign o_allocated    = r_o_alloc;
    assign o_trimmed      = r_o_trimmed;
    assign o_trimmed_slot = r_o_tslot;

endmodule

// File: hdl/frame_buffer_pool_selector.sv
// top level of the frame buffer pool selector
//
//  channel   signals                                          direction
//  request   i_in_valid / o_in_stall, req_type, release, size in
//  result    o_out_valid / i_out_stall, status .. trimmed_slot out
//  config    i_cfg_we, i_cfg_index, i_cfg_data                in
//
// assign loads the request, scans the slots, checks for trim, then commits;
// a trim adds a rescan and check; the slot scan walks one slot per cycle
// post, release, reconfigure and flush load the request, then execute it
// one request is in work at a time; the next is taken while a result waits
// synchronous active-low reset empties the pool and loads the default limits
// a stalled result holds the sequencer in its commit state
module frame_buffer_pool_selector import fbps_pkg::*; #(
    parameter int SLOTS    = 4,
    parameter int AGE_BITS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_req_type,
    input  logic [1:0] i_release_slot,
    input  logic       i_size_nonzero,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_status,
    output logic [1:0] o_chosen_slot,
    output logic [7:0] o_buffer_age,
    output logic       o_allocated,
    output logic       o_trimmed,
    output logic [1:0] o_trimmed_slot,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    fbps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    fbps_dp #(
        .SLOTS    (SLOTS),
        .AGE_BITS (AGE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_req_type     (i_req_type),
        .i_release_slot (i_release_slot),
        .i_size_nonzero (i_size_nonzero),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_status       (o_status),
        .o_chosen_slot  (o_chosen_slot),
        .o_buffer_age   (o_buffer_age),
        .o_allocated    (o_allocated),
        .o_trimmed      (o_trimmed),
        .o_trimmed_slot (o_trimmed_slot)
    );

endmodule
